@@ hw/rtl/csgl_pkg.sv @@
// shared types and constants for the segment glyph lookup block
package csgl_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int CELLS        = 16;
  localparam int DEPTH        = MAX_SEGMENTS / CELLS;
  localparam int CELL_W       = $clog2(CELLS);
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int SLOT_W       = $clog2(MAX_SEGMENTS);
  localparam int COUNT_W      = 9;
  localparam int CODE_W       = 16;
  localparam int SEG_W        = 4 * CODE_W;
  localparam int STEP_W       = (ADDR_W > CELL_W) ? ADDR_W : CELL_W;

  localparam logic [STEP_W-1:0]  LAST_ADDR = STEP_W'(DEPTH - 1);
  localparam logic [STEP_W-1:0]  LAST_CELL = STEP_W'(CELLS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SEGMENTS);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_FOUND       = 2'd0;
  localparam logic [1:0] STATUS_NOT_MAPPED  = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] offset;
    logic [CODE_W-1:0] delta;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;
  } seg_t;

  typedef struct packed {
    logic               hit;
    seg_t               seg;
  } link_t;

  typedef struct packed {
    logic               wr_en;
    logic [CELL_W-1:0]  wr_cell;
    logic [ADDR_W-1:0]  wr_addr;
    seg_t               wr_seg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               cmp_en;
    logic [ADDR_W-1:0]  cmp_addr;
    logic               clear;
    logic [CODE_W-1:0]  ch;
    logic [COUNT_W-1:0] live_count;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_MERGE,
    ST_RESULT
  } state_t;

endpackage

@@ hw/rtl/csgl_ram.sv @@
// generic single-write, single-read ram with registered read data
module csgl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/csgl_cell.sv @@
// one cell of the search chain: a bank of segments, a local first-hit scan and a link stage
module csgl_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [csgl_pkg::CELL_W-1:0] cell_id,
  input  csgl_pkg::cell_ctrl_t       ctrl,
  input  csgl_pkg::link_t            link_in,
  output csgl_pkg::link_t            link_out
);

  logic [csgl_pkg::SEG_W-1:0]  rd_word;
  csgl_pkg::seg_t              rd_seg;
  logic                        bank_we;
  logic [csgl_pkg::SLOT_W-1:0] slot;
  logic                        slot_live;
  logic                        hit_now;
  logic                        own_hit;
  csgl_pkg::seg_t              own_seg;

  assign bank_we = ctrl.wr_en && (ctrl.wr_cell == cell_id);

  csgl_ram #(
    .WIDTH (csgl_pkg::SEG_W),
    .DEPTH (csgl_pkg::DEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (ctrl.wr_addr),
    .wdata (ctrl.wr_seg),
    .re    (ctrl.rd_en),
    .raddr (ctrl.rd_addr),
    .rdata (rd_word)
  );

  assign rd_seg    = csgl_pkg::seg_t'(rd_word);
  assign slot      = {cell_id, ctrl.cmp_addr};
  assign slot_live = {1'b0, slot} < ctrl.live_count;
  // first qualifying slot of this bank sticks, addresses are scanned upward
  assign hit_now   = ctrl.cmp_en && !own_hit && slot_live && (ctrl.ch <= rd_seg.end_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_hit <= 1'b0;
    end else if (ctrl.clear) begin
      own_hit <= 1'b0;
    end else if (hit_now) begin
      own_hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_now) begin
      own_seg <= rd_seg;
    end
  end

  // lower cells win, so a local hit overrides whatever comes from above
  always_ff @(posedge clk) begin
    if (own_hit) begin
      link_out <= '{hit: 1'b1, seg: own_seg};
    end else begin
      link_out <= link_in;
    end
  end

endmodule

@@ hw/rtl/cmap_segment_glyph_lookup_unit.sv @@
// top level of the segment glyph lookup block: control sequencer, cell chain and result register
//
// usage
//   input stream s_axis_*: tuser carries the action (load or lookup), tdata the
//   segment fields and the character. a load transfer writes one segment slot
//   and produces no result. a lookup transfer produces one result transfer on
//   m_axis_* with the glyph id in tdata and the status in tuser. cfg_* writes the
//   live segment count (values above 256 saturate) and is ready whenever rst is
//   low. the user must write it only while the block is idle (not enforced).
// timing
//   a lookup runs in order: bank reads (all 16 cells scan their 16-entry banks in
//   parallel), the last compare, the hit rippling down the cell chain, the load of
//   the output register and the result transfer. bank depth and chain length set
//   how long a lookup takes. one item is worked on at a time.
// reset and stall
//   rst clears the sequencer, the output valid and sets the count to one; the
//   segment banks hold garbage until written. the result sits in an output
//   register, so the next item is accepted while it waits; a second lookup
//   result waits in the sequencer until the register frees up.
module cmap_segment_glyph_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: seg_index[7:0], end_code[23:8], start_code[39:24], id_delta[55:40],
  //        range_offset[71:56], char_code[87:72]
  input  logic [87:0] s_axis_tdata,
  // tuser: action[0]
  input  logic [0:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: glyph_id[15:0]
  output logic [15:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  // segment count register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  csgl_pkg::state_t state;
  csgl_pkg::state_t state_next;

  logic [csgl_pkg::STEP_W-1:0]  step;
  logic [csgl_pkg::STEP_W-1:0]  step_next;
  logic [csgl_pkg::CODE_W-1:0]  ch;
  logic [csgl_pkg::COUNT_W-1:0] live_count;
  logic                         cmp_en;
  logic [csgl_pkg::ADDR_W-1:0]  cmp_addr;

  logic                         out_valid;
  logic [csgl_pkg::CODE_W-1:0]  out_glyph;
  logic [1:0]                   out_status;

  logic                         in_xfer;
  logic                         is_lookup;
  logic                         out_free;
  logic                         sweeping;
  logic                         result_load;

  csgl_pkg::cell_ctrl_t         ctrl;
  csgl_pkg::link_t              links [csgl_pkg::CELLS+1];

  logic [csgl_pkg::CODE_W-1:0]  res_glyph;
  logic [1:0]                   res_status;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign cfg_ready     = !rst;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign is_lookup     = (s_axis_tuser[0] == csgl_pkg::ACT_LOOKUP);
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_glyph;
  assign m_axis_tuser  = out_status;

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      csgl_pkg::ST_IDLE: begin
        if (in_xfer && is_lookup) begin
          state_next = csgl_pkg::ST_SWEEP;
        end
      end
      csgl_pkg::ST_SWEEP: begin
        if (step == csgl_pkg::LAST_ADDR) begin
          state_next = csgl_pkg::ST_DRAIN;
        end
      end
      csgl_pkg::ST_DRAIN: begin
        state_next = csgl_pkg::ST_MERGE;
      end
      csgl_pkg::ST_MERGE: begin
        if (step == csgl_pkg::LAST_CELL) begin
          state_next = csgl_pkg::ST_RESULT;
        end
      end
      csgl_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = csgl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = csgl_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    sweeping      = 1'b0;
    result_load   = 1'b0;
    step_next     = '0;
    case (state)
      csgl_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
      end
      csgl_pkg::ST_SWEEP: begin
        sweeping  = 1'b1;
        step_next = (step == csgl_pkg::LAST_ADDR) ? '0 : step + 1'b1;
      end
      csgl_pkg::ST_DRAIN: begin
        step_next = '0;
      end
      csgl_pkg::ST_MERGE: begin
        step_next = (step == csgl_pkg::LAST_CELL) ? '0 : step + 1'b1;
      end
      csgl_pkg::ST_RESULT: begin
        result_load = out_free;
      end
      default: begin
        step_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csgl_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // ---------------------------------------------------------------------------
  // registers: count, character, compare strobe
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= csgl_pkg::COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      live_count <= (cfg_data > csgl_pkg::COUNT_MAX) ? csgl_pkg::COUNT_MAX : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_lookup) begin
      ch <= s_axis_tdata[87:72];
    end
  end

  // read data lands in the cycle after the address, so the compare follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= sweeping;
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= step[csgl_pkg::ADDR_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl.wr_en             = in_xfer && !is_lookup;
    ctrl.wr_cell           = s_axis_tdata[csgl_pkg::SLOT_W-1:csgl_pkg::ADDR_W];
    ctrl.wr_addr           = s_axis_tdata[csgl_pkg::ADDR_W-1:0];
    ctrl.wr_seg.end_code   = s_axis_tdata[23:8];
    ctrl.wr_seg.start_code = s_axis_tdata[39:24];
    ctrl.wr_seg.delta      = s_axis_tdata[55:40];
    ctrl.wr_seg.offset     = s_axis_tdata[71:56];
    ctrl.rd_en             = sweeping;
    ctrl.rd_addr           = step[csgl_pkg::ADDR_W-1:0];
    ctrl.cmp_en            = cmp_en;
    ctrl.cmp_addr          = cmp_addr;
    ctrl.clear             = in_xfer && is_lookup;
    ctrl.ch                = ch;
    ctrl.live_count        = live_count;
  end

  // the top end of the chain never carries a hit
  assign links[csgl_pkg::CELLS] = '0;

  for (genvar g = 0; g < csgl_pkg::CELLS; g++) begin : g_cell
    csgl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (csgl_pkg::CELL_W'(g)),
      .ctrl     (ctrl),
      .link_in  (links[g+1]),
      .link_out (links[g])
    );
  end

  // ---------------------------------------------------------------------------
  // result forming from the hit at the bottom of the chain
  // ---------------------------------------------------------------------------
  always_comb begin
    res_glyph  = '0;
    res_status = csgl_pkg::STATUS_NOT_MAPPED;
    if (links[0].hit && (ch >= links[0].seg.start_code)) begin
      if (links[0].seg.offset != '0) begin
        res_status = csgl_pkg::STATUS_UNSUPPORTED;
      end else begin
        res_status = csgl_pkg::STATUS_FOUND;
        res_glyph  = ch + links[0].seg.delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_glyph  <= res_glyph;
      out_status <= res_status;
    end
  end

endmodule
